// ===== hw/rtl/msfp_pkg.sv =====
// Shared types and constants for the masked sample frame packer.
// No dependencies; imported by every module of the block.
package msfp_pkg;

   localparam int MAX_CHANNELS = 16;
   localparam int MASK_BITS = 16;
   localparam int CHAN_CAP = (MAX_CHANNELS < MASK_BITS) ? MAX_CHANNELS : MASK_BITS;
   localparam int ITEM_BYTES = 8;

   localparam logic [7:0] SYNC_FIRST = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   localparam logic [7:0] CHECK_INIT = 8'hFF;

   localparam logic REG_CHANNEL_COUNT = 1'b0;
   localparam logic REG_CHANNEL_MASK = 1'b1;

   typedef struct packed {
      logic [ITEM_BYTES-1:0][7:0] data;
      logic [3:0] cnt;
      logic eof;
   } frame_bytes_type;

   typedef struct packed {
      logic [3:0] channel_index;
      logic [7:0] checksum;
   } pack_state_type;

endpackage

// ===== hw/rtl/msfp_build.sv =====
// Builds a registered item's bytes: header, sample, checksum, each if due.
// Depends on msfp_pkg.
module msfp_build (
   input  logic [15:0] sample,
   input  logic [7:0] frame_seq,
   input  logic [4:0] channel_count,
   input  logic [15:0] channel_mask,
   input  msfp_pkg::pack_state_type state_cur,
   output msfp_pkg::pack_state_type state_next,
   output msfp_pkg::frame_bytes_type frame
);
   import msfp_pkg::*;

   logic [4:0] count;
   logic last;
   logic [7:0] cs;
   logic [3:0] pos;

   always_comb begin
      count = channel_count;
      if (count == 5'd0) begin
         count = 5'd1;
      end
      if (count > 5'(CHAN_CAP)) begin
         count = 5'(CHAN_CAP);
      end
      last = ({1'b0, state_cur.channel_index} + 5'd1) >= count;

      frame.data = '0;
      frame.eof = last;
      pos = 4'd0;
      cs = state_cur.checksum;

      if (state_cur.channel_index == 4'd0) begin
         cs = CHECK_INIT ^ frame_seq ^ channel_mask[7:0];
         frame.data[0] = SYNC_FIRST;
         frame.data[1] = SYNC_SECOND;
         frame.data[2] = frame_seq;
         frame.data[3] = channel_mask[7:0];
         pos = 4'd4;
         if (count > 5'd8) begin
            cs = cs ^ channel_mask[15:8];
            frame.data[4] = channel_mask[15:8];
            pos = 4'd5;
         end
      end

      if (channel_mask[state_cur.channel_index]) begin
         cs = cs ^ sample[7:0] ^ sample[15:8];
         frame.data[pos[2:0]] = sample[7:0];
         frame.data[3'(pos + 4'd1)] = sample[15:8];
         pos = pos + 4'd2;
      end

      if (last) begin
         frame.data[pos[2:0]] = cs;
         pos = pos + 4'd1;
         state_next.checksum = CHECK_INIT;
         state_next.channel_index = 4'd0;
      end else begin
         state_next.checksum = cs;
         state_next.channel_index = state_cur.channel_index + 4'd1;
      end
      frame.cnt = pos;
   end

endmodule

// ===== hw/rtl/msfp_serializer.sv =====
// Result buffer: holds one item's bytes; one out per cycle if rsp_ready.
// Depends on msfp_pkg.
module msfp_serializer (
   input  logic clock,
   input  logic reset,
   input  logic load_valid,
   output logic load_ready,
   input  msfp_pkg::frame_bytes_type frame,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_last_of_item,
   output logic rsp_end_of_frame
);
   import msfp_pkg::*;

   logic [ITEM_BYTES-1:0][7:0] data_ff, data_in;
   logic [3:0] cnt_ff, cnt_in;
   logic eof_ff, eof_in;
   logic load;

   assign load_ready = (cnt_ff == 4'd0) || (cnt_ff == 4'd1 && rsp_ready);
   assign load = load_valid && load_ready;

   always_comb begin
      data_in = data_ff;
      cnt_in = cnt_ff;
      eof_in = eof_ff;
      if (load) begin
         data_in = frame.data;
         cnt_in = frame.cnt;
         eof_in = frame.eof;
      end else if (rsp_valid && rsp_ready) begin
         data_in = data_ff >> 8;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
         eof_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         eof_ff <= eof_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = cnt_ff != 4'd0;
   assign rsp_out_byte = data_ff[0];
   assign rsp_last_of_item = cnt_ff == 4'd1;
   assign rsp_end_of_frame = (cnt_ff == 4'd1) && eof_ff;

endmodule

// ===== hw/rtl/masked_sample_frame_packer.sv =====
// Top level of the masked sample frame packer: input register, frame state,
// configuration registers. Depends on msfp_pkg, msfp_build, msfp_serializer.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_sample, req_frame_seq
//   rsp      out        rsp_valid/rsp_ready   rsp_out_byte, rsp_last_of_item,
//                                             rsp_end_of_frame
//   csr      in         csr_write             csr_index, csr_wdata
//
// An item waits in the input register, then its bytes (0 to 7) leave the
// result buffer one per cycle while rsp_ready is high; the next item loads
// as the last byte leaves, so the one-byte output port limits throughput.
// Reset clears the frame position, checksum and both registers to defaults.
// A stalled rsp side holds the buffer; an empty input register takes an item.
module masked_sample_frame_packer (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_sample,
   input  logic [7:0] req_frame_seq,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_last_of_item,
   output logic rsp_end_of_frame,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [15:0] csr_wdata
);
   import msfp_pkg::*;

   logic in_valid_ff, in_valid_in;
   logic [15:0] sample_ff, sample_in;
   logic [7:0] seq_ff, seq_in;
   logic [4:0] count_ff, count_in;
   logic [15:0] mask_ff, mask_in;
   pack_state_type state_ff, state_in, state_next;
   frame_bytes_type frame;
   logic load_ready;
   logic load;

   msfp_build u_build (
      .sample(sample_ff),
      .frame_seq(seq_ff),
      .channel_count(count_ff),
      .channel_mask(mask_ff),
      .state_cur(state_ff),
      .state_next(state_next),
      .frame(frame)
   );

   msfp_serializer u_serializer (
      .clock(clock),
      .reset(reset),
      .load_valid(in_valid_ff),
      .load_ready(load_ready),
      .frame(frame),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_item(rsp_last_of_item),
      .rsp_end_of_frame(rsp_end_of_frame)
   );

   assign load = in_valid_ff && load_ready;
   assign req_ready = !in_valid_ff || load_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      sample_in = sample_ff;
      seq_in = seq_ff;
      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         sample_in = req_sample;
         seq_in = req_frame_seq;
      end
      state_in = load ? state_next : state_ff;
      count_in = count_ff;
      mask_in = mask_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: count_in = csr_wdata[4:0];
            REG_CHANNEL_MASK:  mask_in = csr_wdata;
            default:           count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff.channel_index <= 4'd0;
         state_ff.checksum <= CHECK_INIT;
         count_ff <= 5'd16;
         mask_ff <= 16'hFFFF;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff <= state_in;
         count_ff <= count_in;
         mask_ff <= mask_in;
      end
      sample_ff <= sample_in;
      seq_ff <= seq_in;
   end

endmodule

// ===== verif/masked_sample_frame_packer_test.sv =====
// Self-checking bench for masked_sample_frame_packer: a frame stream predictor in
// a small class checks every output byte against what each accepted sample implies.
// Depends on msfp_pkg and the masked_sample_frame_packer RTL.
`timescale 1ns / 100ps

typedef struct packed {
   logic [7:0] data;
   logic item_end;
   logic frame_end;
} stream_byte_type;

class frame_stream_scoreboard;
   logic [4:0] cfg_count;
   logic [15:0] cfg_mask;
   logic [3:0] chan_idx;
   logic [7:0] checksum;
   stream_byte_type pending_bytes[$];
   int mismatches;

   function new();
      cfg_count = 5'd16;
      cfg_mask = 16'hFFFF;
      chan_idx = 4'd0;
      checksum = msfp_pkg::CHECK_INIT;
      mismatches = 0;
   endfunction

   function void set_reg(logic idx, logic [15:0] val);
      if (idx == msfp_pkg::REG_CHANNEL_COUNT) begin
         cfg_count = val[4:0];
      end else begin
         cfg_mask = val;
      end
   endfunction

   function void emit(logic [7:0] b, bit summed, bit eof);
      if (summed) begin
         checksum = checksum ^ b;
      end
      pending_bytes.push_back('{data: b, item_end: 1'b0, frame_end: eof});
   endfunction

   function void take_sample(logic [15:0] smp, logic [7:0] seq);
      int eff;
      int first;
      bit closes;
      eff = int'(cfg_count);
      if (eff < 1) eff = 1;
      if (eff > msfp_pkg::CHAN_CAP) eff = msfp_pkg::CHAN_CAP;
      closes = (int'(chan_idx) + 1 >= eff);
      first = pending_bytes.size();
      if (chan_idx == 4'd0) begin
         checksum = msfp_pkg::CHECK_INIT;
         emit(msfp_pkg::SYNC_FIRST, 1'b0, 1'b0);
         emit(msfp_pkg::SYNC_SECOND, 1'b0, 1'b0);
         emit(seq, 1'b1, 1'b0);
         emit(cfg_mask[7:0], 1'b1, 1'b0);
         if (eff > 8) emit(cfg_mask[15:8], 1'b1, 1'b0);
      end
      if (cfg_mask[chan_idx]) begin
         emit(smp[7:0], 1'b1, 1'b0);
         emit(smp[15:8], 1'b1, 1'b0);
      end
      if (closes) begin
         emit(checksum, 1'b0, 1'b1);
         checksum = msfp_pkg::CHECK_INIT;
         chan_idx = 4'd0;
      end else begin
         chan_idx = chan_idx + 4'd1;
      end
      if (pending_bytes.size() > first) begin
         pending_bytes[pending_bytes.size() - 1].item_end = 1'b1;
      end
   endfunction

   function void check_byte(logic [7:0] b, logic item_end, logic frame_end);
      stream_byte_type want;
      if (pending_bytes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: unexpected byte %h last=%b eof=%b", $time, b, item_end, frame_end);
         end
         return;
      end
      want = pending_bytes.pop_front();
      if (want.data !== b || want.item_end !== item_end || want.frame_end !== frame_end) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: byte mismatch: expected %h last=%b eof=%b, got %h last=%b eof=%b",
                     $time, want.data, want.item_end, want.frame_end, b, item_end, frame_end);
         end
      end
   endfunction

   function int pending();
      return pending_bytes.size();
   endfunction
endclass

module masked_sample_frame_packer_test;
   import msfp_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 350;
   localparam int TAIL_CYCLES = 8;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [15:0] req_sample;
   logic [7:0] req_frame_seq;
   logic rsp_valid;
   logic rsp_ready;
   logic [7:0] rsp_out_byte;
   logic rsp_last_of_item;
   logic rsp_end_of_frame;
   logic csr_write;
   logic csr_index;
   logic [15:0] csr_wdata;

   frame_stream_scoreboard sb;
   bit snd_idle;
   bit rsp_idle;
   int hold_request;
   int cycles;

   masked_sample_frame_packer i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_frame_seq(req_frame_seq),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_item(rsp_last_of_item),
      .rsp_end_of_frame(rsp_end_of_frame),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("masked_sample_frame_packer_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_byte(rsp_out_byte, rsp_last_of_item, rsp_end_of_frame);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random back-pressure plus long holds on request
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end else if (rsp_idle) begin
            n = pick_gap();
            if (n > 0) begin
               rsp_ready = 1'b0;
               repeat (n) @(negedge clock);
            end
         end
         rsp_ready = 1'b1;
      end
   end

   task automatic send_item(input logic [15:0] smp, input logic [7:0] seq);
      int gap;
      gap = snd_idle ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_sample = smp;
      req_frame_seq = seq;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.take_sample(smp, seq);
   endtask

   // drop valid and wait for the stream to drain
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic write_count(input logic [4:0] cnt);
      write_reg(REG_CHANNEL_COUNT, {11'($urandom), cnt});
   endtask

   initial begin
      int sent;
      int phase;
      int n;
      logic [4:0] cnt;
      logic [15:0] msk;
      sb = new();
      cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = 16'h0000;
      req_frame_seq = 8'h00;
      csr_write = 1'b0;
      csr_index = REG_CHANNEL_COUNT;
      csr_wdata = 16'h0000;
      snd_idle = 1'b1;
      rsp_idle = 1'b1;
      hold_request = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // short frame, mask bits set beyond the count, field extremes
      write_count(5'd3);
      write_reg(REG_CHANNEL_MASK, 16'hFFFF);
      send_item(16'h7FFF, 8'h00);
      send_item(16'h8000, 8'hFF);
      send_item(16'hFFFF, 8'hA5);
      settle();

      // zero count acts as a single channel
      write_count(5'd0);
      send_item(16'h0000, 8'hFF);
      send_item(16'h1234, 8'h5A);
      settle();

      // two mask bytes, silent middle channels
      write_count(5'd9);
      write_reg(REG_CHANNEL_MASK, 16'h0100);
      repeat (9) send_item(pick_sample(), 8'($urandom));
      settle();

      // mask and count changed inside a frame
      write_count(5'd4);
      write_reg(REG_CHANNEL_MASK, 16'h000F);
      send_item(16'h0102, 8'h33);
      send_item(16'h0304, 8'h44);
      settle();
      write_reg(REG_CHANNEL_MASK, 16'h000A);
      send_item(16'h0506, 8'h55);
      settle();
      write_count(5'd2);
      send_item(16'h0708, 8'h66);
      settle();

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 9))
            0: cnt = 5'd0;
            1: cnt = 5'd1;
            2: cnt = 5'd16;
            3: cnt = 5'($urandom_range(17, 31));
            default: cnt = 5'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 5))
            0: msk = 16'h0000;
            1: msk = 16'hFFFF;
            default: msk = 16'($urandom);
         endcase
         case ($urandom_range(0, 3))
            1: write_count(cnt);
            2: write_reg(REG_CHANNEL_MASK, msk);
            3: begin
               write_count(cnt);
               write_reg(REG_CHANNEL_MASK, msk);
            end
            default: ;
         endcase
         snd_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         n = $urandom_range(1, 40);
         if (phase == 2) begin
            snd_idle = 1'b0;
            hold_request = 200;
            n = 40;
         end
         repeat (n) send_item(pick_sample(), 8'($urandom));
         sent += n;
         phase++;
      end

      settle();
      repeat (20) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("masked_sample_frame_packer_test: PASS");
      end else begin
         if (sb.pending() > 0) $display("%0d expected bytes never arrived", sb.pending());
         $display("masked_sample_frame_packer_test: FAIL");
      end
      $finish;
   end

endmodule
